@@ design/lssnf_pkg.sv @@
// shared constants and controller/datapath interface types for the newest-first slot sorter
package lssnf_pkg;

  localparam int ENTRIES = 32;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [TIME_W-1:0] SYNC_RESET = TIME_W'(1000000000);

  typedef struct packed {
    logic insert;     // accepted slot goes through the insertion array
    logic pop;        // head result transferred, shift list toward head
    logic clear_run;  // end of run, restart slot numbering
  } dp_cmd_t;

  typedef struct packed {
    logic run_last;   // head result is the last one of the run
  } dp_status_t;

endpackage

@@ design/log_slot_sort_newest_first_unit.sv @@
// top level of the newest-first log slot sorter
//
//  channel | handshake                     | payload
//  --------+-------------------------------+-----------------------------------------------
//  in      | in_valid / in_stall           | slot_time, final_slot
//  out     | out_valid / out_stall         | slot_index, entry_time, time_synced,
//          |                               | entry_valid, run_last
//  cfg     | cfg_valid / cfg_ready         | cfg_data (sync threshold)
//
// slots are taken one per cycle while collecting; each of a run's first ENTRIES slots with
// nonzero slot_time goes through a parallel compare-and-shift row of ENTRIES cells in that
// cycle. the final slot moves the block to draining: one result per cycle while out_stall
// is low, from the head, max(valid slots, 1) results, while in_stall stays high. rst is
// synchronous; it clears the counters and state machine and loads the threshold reset
// value. no clearing pass: row is read only below its fill count. cfg_ready is always high.
module log_slot_sort_newest_first_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lssnf_pkg::TIME_W-1:0] slot_time,
  input  logic                         final_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lssnf_pkg::SLOT_W-1:0] slot_index,
  output logic [lssnf_pkg::TIME_W-1:0] entry_time,
  output logic                         time_synced,
  output logic                         entry_valid,
  output logic                         run_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lssnf_pkg::TIME_W-1:0] cfg_data
);

  lssnf_pkg::dp_cmd_t    cmd;
  lssnf_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  lssnf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .final_slot (final_slot),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lssnf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .slot_time   (slot_time),
    .cmd         (cmd),
    .status      (status),
    .slot_index  (slot_index),
    .entry_time  (entry_time),
    .time_synced (time_synced),
    .entry_valid (entry_valid),
    .run_last    (run_last)
  );

endmodule

@@ design/lssnf_ctrl.sv @@
// controller: collects slots, then drains the sorted list
module lssnf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   final_slot,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  lssnf_pkg::dp_status_t  status,
  output lssnf_pkg::dp_cmd_t     cmd
);

  typedef enum logic [1:0] {
    COLLECT = 2'b01,
    DRAIN   = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall  = (state != COLLECT);
  assign out_valid = (state == DRAIN);
  assign accept    = in_valid && (state == COLLECT);

  always_comb begin
    state_next    = state;
    cmd.insert    = 1'b0;
    cmd.pop       = 1'b0;
    cmd.clear_run = 1'b0;
    unique case (state)
      COLLECT: begin
        cmd.insert = accept;
        if (accept && final_slot) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        cmd.pop = !out_stall;
        if (!out_stall && status.run_last) begin
          cmd.clear_run = 1'b1;
          state_next    = COLLECT;
        end
      end
      default: begin
        state_next = COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= COLLECT;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/lssnf_dp.sv @@
// datapath: compare-and-shift insertion array, counters and sync threshold
module lssnf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [lssnf_pkg::TIME_W-1:0]        cfg_data,
  input  logic [lssnf_pkg::TIME_W-1:0]        slot_time,
  input  lssnf_pkg::dp_cmd_t                  cmd,
  output lssnf_pkg::dp_status_t               status,
  output logic [lssnf_pkg::SLOT_W-1:0]        slot_index,
  output logic [lssnf_pkg::TIME_W-1:0]        entry_time,
  output logic                                time_synced,
  output logic                                entry_valid,
  output logic                                run_last
);

  localparam int N = lssnf_pkg::ENTRIES;

  logic [lssnf_pkg::TIME_W-1:0] times      [N];
  logic [lssnf_pkg::SLOT_W-1:0] slots      [N];
  logic [lssnf_pkg::TIME_W-1:0] times_next [N];
  logic [lssnf_pkg::SLOT_W-1:0] slots_next [N];
  logic [N-1:0]                 gt;
  logic [lssnf_pkg::CNT_W-1:0]  count;
  logic [lssnf_pkg::CNT_W-1:0]  count_next;
  logic [lssnf_pkg::CNT_W-1:0]  slot_cnt;
  logic [lssnf_pkg::CNT_W-1:0]  slot_cnt_next;
  logic [lssnf_pkg::TIME_W-1:0] threshold;
  logic                         in_range;
  logic                         do_ins;
  logic [lssnf_pkg::SLOT_W-1:0] new_slot;

  assign in_range = (slot_cnt < lssnf_pkg::CNT_W'(N));
  assign do_ins   = cmd.insert && in_range && (slot_time != '0)
                    && (count < lssnf_pkg::CNT_W'(N));
  assign new_slot = lssnf_pkg::SLOT_W'(slot_cnt);

  // held entries that stay ahead of the new one (later slot wins ties)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (lssnf_pkg::CNT_W'(i) < count) && (times[i] > slot_time);
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      times_next[i] = times[i];
      slots_next[i] = slots[i];
      if (cmd.pop) begin
        if (i < N - 1) begin
          times_next[i] = times[(i + 1) % N];
          slots_next[i] = slots[(i + 1) % N];
        end
      end else if (do_ins && !gt[i] && (lssnf_pkg::CNT_W'(i) <= count)) begin
        if (i == 0 || gt[(i + N - 1) % N]) begin
          times_next[i] = slot_time;
          slots_next[i] = new_slot;
        end else begin
          times_next[i] = times[(i + N - 1) % N];
          slots_next[i] = slots[(i + N - 1) % N];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.pop) begin
      if (count != '0) begin
        count_next = count - 1'b1;
      end
    end else if (do_ins) begin
      count_next = count + 1'b1;
    end
  end

  always_comb begin
    slot_cnt_next = slot_cnt;
    if (cmd.clear_run) begin
      slot_cnt_next = '0;
    end else if (cmd.insert && in_range) begin
      slot_cnt_next = slot_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      times[i] <= times_next[i];
      slots[i] <= slots_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      slot_cnt  <= '0;
      threshold <= lssnf_pkg::SYNC_RESET;
    end else begin
      count    <= count_next;
      slot_cnt <= slot_cnt_next;
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
    end
  end

  // empty run shows a single marker with all payload fields zero but run_last, which is set
  assign entry_valid   = (count != '0);
  assign run_last      = (count <= lssnf_pkg::CNT_W'(1));
  assign slot_index    = entry_valid ? slots[0] : '0;
  assign entry_time    = entry_valid ? times[0] : '0;
  assign time_synced   = entry_valid && (times[0] >= threshold);
  assign status.run_last = run_last;

endmodule
